@@ sv/lsa_pkg.sv @@
// package with types, constants and helpers shared by the linked slot allocator
package lsa_pkg;

    localparam int unsigned SLOTS  = 1024;
    localparam int unsigned IDX_W  = $clog2(SLOTS + 1);
    localparam int unsigned SLOT_W = 10;

    localparam logic [IDX_W-1:0] SLOT_NONE = IDX_W'(SLOTS);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_NONE_USED = 2'd2
    } t_status;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_slot;
        logic [IDX_W-1:0]  in_use;
        logic [IDX_W-1:0]  newest_slot;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_SELF,
        S_NBRS
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_ALLOC,
        DP_UNLINK,
        DP_SELF,
        DP_NBRS
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    finish;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic is_free;
        logic full;
        logic empty;
        logic slot_oob;
    } t_stat;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
        return (v <= SLOT_NONE) ? v : SLOT_NONE;
    endfunction

endpackage

@@ sv/linked_slot_allocator.sv @@
// top level of the linked slot allocator
//
//  channel  | control       | payload
//  ---------+---------------+------------------------------
//  request  | start / busy  | i_req    (operation, slot)
//  result   | o_done        | o_result (status, granted_slot, in_use, newest_slot)
//
// an allocate goes from accepted start through the evaluate state to the o_done strobe;
// a free does one registered read of both link memories, then three link write steps
// (unlink, self, neighbours), set by the single write port of each link memory
// failed requests end in the evaluate state with no link write
// after reset a clearing pass writes every entry of both link memories to rebuild the chain with busy high
// results show for one cycle on o_done and cannot be held off
module linked_slot_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  lsa_pkg::t_req    i_req,
    output logic             busy,
    output logic             o_done,
    output lsa_pkg::t_result o_result
);

    lsa_pkg::t_cmd  cmd;
    lsa_pkg::t_stat stat;

    lsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lsa_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a request in flight");

    a_in_use_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.in_use <= lsa_pkg::SLOT_NONE))
        else $error("in_use above slot count");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != lsa_pkg::STATUS_DONE) |->
        (o_result.granted_slot == '0))
        else $error("granted slot on failed request");
`endif

endmodule

@@ sv/lsa_ctrl.sv @@
// controller state machine sequencing the link reads and writes of each request
module lsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lsa_pkg::t_stat i_stat,
    output lsa_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    lsa_pkg::t_state r_state;
    lsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsa_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = lsa_pkg::DP_NOP;
        o_cmd.finish  = 1'b0;
        o_cmd.status  = lsa_pkg::STATUS_DONE;
        o_busy        = 1'b1;
        case (r_state)
            lsa_pkg::S_INIT: begin
                o_cmd.op = lsa_pkg::DP_INIT;
                if (i_stat.init_last) begin
                    n_state = lsa_pkg::S_IDLE;
                end
            end
            lsa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.op = lsa_pkg::DP_LOAD;
                    n_state  = lsa_pkg::S_EVAL;
                end
            end
            lsa_pkg::S_EVAL: begin
                n_state = lsa_pkg::S_IDLE;
                if (!i_stat.is_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.status = lsa_pkg::STATUS_NO_FREE;
                    end else begin
                        o_cmd.op = lsa_pkg::DP_ALLOC;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = lsa_pkg::STATUS_NONE_USED;
                end else if (i_stat.slot_oob) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.op = lsa_pkg::DP_UNLINK;
                    n_state  = lsa_pkg::S_SELF;
                end
            end
            lsa_pkg::S_SELF: begin
                o_cmd.op = lsa_pkg::DP_SELF;
                n_state  = lsa_pkg::S_NBRS;
            end
            lsa_pkg::S_NBRS: begin
                o_cmd.op     = lsa_pkg::DP_NBRS;
                o_cmd.finish = 1'b1;
                n_state      = lsa_pkg::S_IDLE;
            end
            default: begin
                n_state = lsa_pkg::S_INIT;
            end
        endcase
    end

endmodule

@@ sv/lsa_datapath.sv @@
// datapath with link memories, chain pointers, use counter and result register
module lsa_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsa_pkg::t_cmd    i_cmd,
    input  lsa_pkg::t_req    i_req,
    output lsa_pkg::t_stat   o_stat,
    output logic             o_done,
    output lsa_pkg::t_result o_result
);

    localparam int unsigned IW = lsa_pkg::IDX_W;

    logic [IW-1:0] r_fwd_mem [0:lsa_pkg::SLOTS];
    logic [IW-1:0] r_bwd_mem [0:lsa_pkg::SLOTS];

    logic [IW-1:0]              r_fwd_q;
    logic [IW-1:0]              r_bwd_q;
    logic [IW-1:0]              r_init_idx;
    logic [IW-1:0]              r_newest;
    logic [IW-1:0]              r_first_free;
    logic [IW-1:0]              r_used;
    logic                       r_op;
    logic [lsa_pkg::SLOT_W-1:0] r_slot;
    logic                       r_done;
    lsa_pkg::t_result           r_result;

    logic [IW-1:0] n_newest;
    logic [IW-1:0] n_first_free;
    logic [IW-1:0] n_used;

    logic          fwd_we;
    logic [IW-1:0] fwd_waddr;
    logic [IW-1:0] fwd_wdata;
    logic          bwd_we;
    logic [IW-1:0] bwd_waddr;
    logic [IW-1:0] bwd_wdata;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic [IW-1:0] slot_ext;
    logic [IW-1:0] prev_idx;
    logic [IW-1:0] next_idx;

    assign slot_ext = IW'(r_slot);
    assign prev_idx = lsa_pkg::clamp_idx(r_bwd_q);
    assign next_idx = lsa_pkg::clamp_idx(r_fwd_q);

    always_comb begin
        n_newest     = r_newest;
        n_first_free = r_first_free;
        n_used       = r_used;
        fwd_we       = 1'b0;
        fwd_waddr    = r_init_idx;
        fwd_wdata    = '0;
        bwd_we       = 1'b0;
        bwd_waddr    = r_init_idx;
        bwd_wdata    = '0;
        rd_en        = 1'b0;
        rd_addr      = r_first_free;
        case (i_cmd.op)
            lsa_pkg::DP_INIT: begin
                fwd_we    = 1'b1;
                fwd_wdata = (r_init_idx == lsa_pkg::SLOT_NONE) ? '0 : r_init_idx + 1'b1;
                bwd_we    = 1'b1;
                bwd_wdata = (r_init_idx == '0) ? lsa_pkg::SLOT_NONE : r_init_idx - 1'b1;
            end
            lsa_pkg::DP_LOAD: begin
                rd_en = 1'b1;
                if (i_req.operation == lsa_pkg::OP_FREE) begin
                    rd_addr = IW'(i_req.slot);
                end
            end
            lsa_pkg::DP_ALLOC: begin
                n_newest     = r_first_free;
                n_first_free = next_idx;
                n_used       = r_used + 1'b1;
            end
            lsa_pkg::DP_UNLINK: begin
                fwd_we    = 1'b1;
                fwd_waddr = prev_idx;
                fwd_wdata = next_idx;
                bwd_we    = 1'b1;
                bwd_waddr = next_idx;
                bwd_wdata = prev_idx;
                if (slot_ext == r_newest) begin
                    n_newest = prev_idx;
                end
            end
            lsa_pkg::DP_SELF: begin
                fwd_we    = 1'b1;
                fwd_waddr = slot_ext;
                fwd_wdata = r_first_free;
                bwd_we    = 1'b1;
                bwd_waddr = slot_ext;
                bwd_wdata = r_newest;
            end
            lsa_pkg::DP_NBRS: begin
                fwd_we       = 1'b1;
                fwd_waddr    = r_newest;
                fwd_wdata    = slot_ext;
                bwd_we       = 1'b1;
                bwd_waddr    = r_first_free;
                bwd_wdata    = slot_ext;
                n_first_free = slot_ext;
                n_used       = r_used - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // link memories
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (bwd_we) begin
            r_bwd_mem[bwd_waddr] <= bwd_wdata;
        end
        if (rd_en) begin
            r_fwd_q <= r_fwd_mem[rd_addr];
            r_bwd_q <= r_bwd_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx   <= '0;
            r_newest     <= lsa_pkg::SLOT_NONE;
            r_first_free <= '0;
            r_used       <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cmd.op == lsa_pkg::DP_INIT) begin
                r_init_idx <= r_init_idx + 1'b1;
            end
            r_newest     <= n_newest;
            r_first_free <= n_first_free;
            r_used       <= n_used;
            r_done       <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lsa_pkg::DP_LOAD) begin
            r_op   <= i_req.operation;
            r_slot <= i_req.slot;
        end
        if (i_cmd.finish) begin
            r_result.status       <= i_cmd.status;
            r_result.granted_slot <= (i_cmd.op == lsa_pkg::DP_ALLOC) ?
                                     r_first_free[lsa_pkg::SLOT_W-1:0] : '0;
            r_result.in_use       <= n_used;
            r_result.newest_slot  <= n_newest;
        end
    end

    assign o_stat.init_last = (r_init_idx == lsa_pkg::SLOT_NONE);
    assign o_stat.is_free   = (r_op == lsa_pkg::OP_FREE);
    assign o_stat.full      = (r_used == lsa_pkg::SLOT_NONE);
    assign o_stat.empty     = (r_used == '0);
    assign o_stat.slot_oob  = (slot_ext >= lsa_pkg::SLOT_NONE);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
